@@ design/rmt_pkg.sv @@
package rmt_pkg;

  // Field widths of the channels and of the configuration register.
  localparam int CmdW   = 2;
  localparam int PosW   = 10;
  localparam int ValW   = 32;
  localparam int CountW = 11;

  // Command codes carried in the command field of an input beat.
  localparam logic [CmdW-1:0] CmdLoad  = 2'd0;
  localparam logic [CmdW-1:0] CmdQuery = 2'd1;
  localparam logic [CmdW-1:0] CmdShift = 2'd2;

  typedef struct packed {
    logic [CmdW-1:0] command;
    logic [PosW-1:0] position;
    logic [PosW-1:0] range_end;
    logic [ValW-1:0] load_value;
    logic            last_position;
  } rmt_in_t;

  typedef struct packed {
    logic [ValW-1:0] minimum;
    logic            range_error;
  } rmt_out_t;

  // Operations the tree engine carries out.
  typedef enum logic [1:0] {
    OpLoad,
    OpQuery,
    OpSwap,
    OpError
  } rmt_op_e;

  typedef struct packed {
    rmt_op_e         op;
    logic [PosW-1:0] pos_a;
    logic [PosW-1:0] pos_b;
    logic [ValW-1:0] value;
  } rmt_start_t;

endpackage

@@ design/rmt_mem.sv @@
module rmt_mem #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  output logic [WIDTH-1:0] rdata_a_o,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and two read ports, read data registered.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

@@ design/rmt_engine.sv @@
module rmt_engine import rmt_pkg::*; #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int VALUE_WIDTH  = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_valid_i,
  input  rmt_start_t start_i,
  output logic       busy_o,
  output logic       res_valid_o,
  input  logic       res_ready_i,
  output rmt_out_t   res_o
);

  localparam int NW    = $clog2(2 * MAX_ELEMENTS);
  localparam int QW    = NW + 1;
  localparam int Depth = 2 * MAX_ELEMENTS;

  localparam logic [2:0] SIdle   = 3'd0;
  localparam logic [2:0] SLeaf   = 3'd1;
  localparam logic [2:0] SUp     = 3'd2;
  localparam logic [2:0] SSwapRd = 3'd3;
  localparam logic [2:0] SQuery  = 3'd4;
  localparam logic [2:0] SResult = 3'd5;

  logic [2:0]             state_q, state_d;
  logic                   sec_pend_q, sec_pend_d;
  logic                   va_q, va_d;
  logic                   vb_q, vb_d;
  logic [NW-1:0]          node_q, node_d;
  logic [NW-1:0]          sec_node_q, sec_node_d;
  logic [VALUE_WIDTH-1:0] cur_q, cur_d;
  logic [VALUE_WIDTH-1:0] sec_val_q, sec_val_d;
  logic [VALUE_WIDTH-1:0] best_q, best_d;
  logic                   err_q, err_d;
  logic [QW-1:0]          l_q, l_d;
  logic [QW-1:0]          r_q, r_d;

  logic                   mem_we;
  logic [NW-1:0]          mem_waddr;
  logic [VALUE_WIDTH-1:0] mem_wdata;
  logic [NW-1:0]          raddr_a, raddr_b;
  logic [VALUE_WIDTH-1:0] rdata_a, rdata_b;

  logic [NW-1:0]          parent;
  logic [VALUE_WIDTH-1:0] up_val;
  logic [VALUE_WIDTH-1:0] q_a;
  logic [VALUE_WIDTH-1:0] q_min;
  logic [NW-1:0]          leaf_a, leaf_b;

  rmt_mem #(
    .DEPTH (Depth),
    .WIDTH (VALUE_WIDTH)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (raddr_a),
    .rdata_a_o (rdata_a),
    .raddr_b_i (raddr_b),
    .rdata_b_o (rdata_b)
  );

  assign leaf_a = NW'(MAX_ELEMENTS) + NW'(start_i.pos_a);
  assign leaf_b = NW'(MAX_ELEMENTS) + NW'(start_i.pos_b);

  // The sibling read issued last cycle meets the value just written on the path.
  assign parent = node_q >> 1;
  assign up_val = (rdata_a < cur_q) ? rdata_a : cur_q;

  // Fold the up to two nodes returned for the previous query level.
  assign q_a   = (va_q && (rdata_a < best_q)) ? rdata_a : best_q;
  assign q_min = (vb_q && (rdata_b < q_a)) ? rdata_b : q_a;

  always_comb begin
    state_d    = state_q;
    sec_pend_d = sec_pend_q;
    va_d       = va_q;
    vb_d       = vb_q;
    node_d     = node_q;
    sec_node_d = sec_node_q;
    cur_d      = cur_q;
    sec_val_d  = sec_val_q;
    best_d     = best_q;
    err_d      = err_q;
    l_d        = l_q;
    r_d        = r_q;
    mem_we     = 1'b0;
    mem_waddr  = node_q;
    mem_wdata  = cur_q;
    raddr_a    = node_q ^ NW'(1);
    raddr_b    = node_q;

    case (state_q)
      SIdle: begin
        if (start_valid_i) begin
          case (start_i.op)
            OpLoad: begin
              node_d  = leaf_a;
              cur_d   = VALUE_WIDTH'(start_i.value);
              state_d = SLeaf;
            end
            OpSwap: begin
              node_d     = leaf_a;
              sec_node_d = leaf_b;
              raddr_a    = leaf_a;
              raddr_b    = leaf_b;
              state_d    = SSwapRd;
            end
            OpQuery: begin
              l_d     = QW'(MAX_ELEMENTS) + QW'(start_i.pos_a);
              r_d     = QW'(MAX_ELEMENTS) + QW'(start_i.pos_b) + QW'(1);
              best_d  = '1;
              err_d   = 1'b0;
              va_d    = 1'b0;
              vb_d    = 1'b0;
              state_d = SQuery;
            end
            OpError: begin
              best_d  = '0;
              err_d   = 1'b1;
              state_d = SResult;
            end
            default: begin
              state_d = SIdle;
            end
          endcase
        end
      end
      SSwapRd: begin
        // The first leaf takes the second one's value, and the other way round.
        cur_d      = rdata_b;
        sec_val_d  = rdata_a;
        sec_pend_d = 1'b1;
        state_d    = SLeaf;
      end
      SLeaf: begin
        mem_we    = 1'b1;
        mem_waddr = node_q;
        mem_wdata = cur_q;
        raddr_a   = node_q ^ NW'(1);
        state_d   = SUp;
      end
      SUp: begin
        mem_we    = 1'b1;
        mem_waddr = parent;
        mem_wdata = up_val;
        raddr_a   = parent ^ NW'(1);
        node_d    = parent;
        cur_d     = up_val;
        if (parent == NW'(1)) begin
          if (sec_pend_q) begin
            node_d     = sec_node_q;
            cur_d      = sec_val_q;
            sec_pend_d = 1'b0;
            state_d    = SLeaf;
          end else begin
            state_d = SIdle;
          end
        end
      end
      SQuery: begin
        best_d = q_min;
        if (l_q < r_q) begin
          raddr_a = NW'(l_q);
          raddr_b = NW'(r_q - QW'(1));
          va_d    = l_q[0];
          vb_d    = r_q[0];
          l_d     = (l_q + QW'(l_q[0])) >> 1;
          r_d     = r_q >> 1;
        end else begin
          va_d    = 1'b0;
          vb_d    = 1'b0;
          state_d = SResult;
        end
      end
      SResult: begin
        if (res_ready_i) begin
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SIdle;
      sec_pend_q <= 1'b0;
      va_q       <= 1'b0;
      vb_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      sec_pend_q <= sec_pend_d;
      va_q       <= va_d;
      vb_q       <= vb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q     <= node_d;
    sec_node_q <= sec_node_d;
    cur_q      <= cur_d;
    sec_val_q  <= sec_val_d;
    best_q     <= best_d;
    err_q      <= err_d;
    l_q        <= l_d;
    r_q        <= r_d;
  end

  assign busy_o            = (state_q != SIdle);
  assign res_valid_o       = (state_q == SResult);
  assign res_o.minimum     = ValW'(best_q);
  assign res_o.range_error = err_q;

endmodule

@@ design/range_minimum_tree_with_rotate_core.sv @@
// Range-minimum tree with rotate.
// Input beats (in_valid_i/in_ready_o, in_data_i) carry one command each: load a
// leaf, query an inclusive range, or name one position of a shift list. Only a
// query produces an output beat (out_valid_o/out_ready_i, out_data_o) holding
// the range minimum or the range error flag. The configuration port sets the
// element count whenever cfg_we_i is high, clamped to 1..MAX_ELEMENTS.
// The tree memory's single write port sets the pace: every tree level on a
// written path takes its own write, and a shift swap rewrites two leaf paths.
// Shift items that only open a list, out-of-range loads and unknown commands
// never start the engine.
// The next beat is accepted as soon as the engine is idle again.
// A finished result waits in the output register; further beats are accepted
// while it waits, and only a second query result stalls until the first is taken.
// Reset clears the control state, sets the element count to its reset value and
// ends any shift list; tree contents are undefined until written.
module range_minimum_tree_with_rotate_core import rmt_pkg::*; #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int VALUE_WIDTH  = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rmt_in_t           in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rmt_out_t          out_data_o,
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_wdata_i
);

  localparam int CountReset = (MAX_ELEMENTS < 1024) ? MAX_ELEMENTS : 1024;

  logic [CountW-1:0] count_q, count_d;
  logic              shift_busy_q, shift_busy_d;
  logic [PosW-1:0]   shift_prev_q, shift_prev_d;
  logic              out_valid_q, out_valid_d;
  rmt_out_t          out_q;

  logic              in_fire;
  logic              pos_ok;
  logic              end_ok;
  logic [PosW-1:0]   prev_sel;
  logic              start_valid;
  rmt_start_t        start;
  logic              eng_busy;
  logic              eng_res_valid;
  logic              res_ready;
  rmt_out_t          eng_res;

  assign in_ready_o = !eng_busy;
  assign in_fire    = in_valid_i && in_ready_o;

  // Range checks against the element count in use.
  assign pos_ok   = CountW'(in_data_i.position) < count_q;
  assign end_ok   = CountW'(in_data_i.range_end) < count_q;
  // A remembered position beyond a shrunken count falls back to the new one.
  assign prev_sel = (CountW'(shift_prev_q) < count_q) ? shift_prev_q : in_data_i.position;

  always_comb begin
    start_valid  = 1'b0;
    start.op     = OpLoad;
    start.pos_a  = in_data_i.position;
    start.pos_b  = in_data_i.range_end;
    start.value  = in_data_i.load_value;
    shift_busy_d = shift_busy_q;
    shift_prev_d = shift_prev_q;

    if (in_fire) begin
      case (in_data_i.command)
        CmdLoad: begin
          start_valid = pos_ok;
        end
        CmdQuery: begin
          start_valid = 1'b1;
          if ((in_data_i.position > in_data_i.range_end) || !end_ok) begin
            start.op = OpError;
          end else begin
            start.op = OpQuery;
          end
        end
        CmdShift: begin
          if (pos_ok) begin
            if (!shift_busy_q) begin
              // The first position of a list is only remembered.
              shift_busy_d = 1'b1;
              shift_prev_d = in_data_i.position;
            end else begin
              start_valid  = 1'b1;
              start.op     = OpSwap;
              start.pos_a  = prev_sel;
              start.pos_b  = in_data_i.position;
              shift_prev_d = in_data_i.position;
            end
          end
          if (in_data_i.last_position) begin
            shift_busy_d = 1'b0;
            shift_prev_d = '0;
          end
        end
        default: begin
          start_valid = 1'b0;
        end
      endcase
    end
  end

  // Element count register, clamped to the supported range.
  always_comb begin
    count_d = count_q;
    if (cfg_we_i) begin
      if (cfg_wdata_i == '0) begin
        count_d = CountW'(1);
      end else if (32'(cfg_wdata_i) > MAX_ELEMENTS) begin
        count_d = CountW'(MAX_ELEMENTS);
      end else begin
        count_d = cfg_wdata_i;
      end
    end
  end

  rmt_engine #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .VALUE_WIDTH  (VALUE_WIDTH)
  ) u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_valid_i (start_valid),
    .start_i       (start),
    .busy_o        (eng_busy),
    .res_valid_o   (eng_res_valid),
    .res_ready_i   (res_ready),
    .res_o         (eng_res)
  );

  // The output register takes a new result when empty or being drained.
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (eng_res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= CountW'(CountReset);
      shift_busy_q <= 1'b0;
      shift_prev_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      count_q      <= count_d;
      shift_busy_q <= shift_busy_d;
      shift_prev_q <= shift_prev_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eng_res_valid && res_ready) begin
      out_q <= eng_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_result_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    eng_res_valid && res_ready |=> out_valid_o)
    else $error("engine result was not captured by the output register");

  a_shift_list_ends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (in_data_i.command == CmdShift) && in_data_i.last_position
    |=> !shift_busy_q && (shift_prev_q == '0))
    else $error("shift list state survived a last position");

  a_busy_after_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_valid |=> !in_ready_o)
    else $error("input accepted while the engine works on an item");
`endif

endmodule
